/* hdl/gb5_pkg.sv */
// Shared types and constants of the 5x5 Gaussian blur.
// No dependencies; used by gb5_conv and gaussian_blur_5x5_rgb.
`timescale 1ns / 1ps

package gb5_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	// Output queue sizing: PIPE_DEPTH items may be in flight ahead of the queue
	localparam int FIFO_DEPTH = 8;
	localparam int PIPE_DEPTH = 4;

	localparam logic [10:0] IMG_WIDTH_RESET  = 11'd1024;
	localparam logic [15:0] IMG_HEIGHT_RESET = 16'd1024;

	// Register select on paddr[2]
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// floor(x / 273) == (x * RECIP_273) >> RECIP_SHIFT for x below 249475
	localparam logic [17:0] RECIP_273   = 18'd245821;
	localparam int          RECIP_SHIFT = 26;

	localparam logic [5:0] KERN [0:4][0:4] = '{
		'{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
		'{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
		'{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
		'{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
		'{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
	};

	// Per-request control riding along with the column vector
	typedef struct packed {
		logic       emit;
		logic       last;
		logic [4:0] row_ok;
		logic [4:0] col_ok;
	} tap_ctl_t;

endpackage

/* hdl/gb5_conv.sv */
// Window, weighted sums and divide-by-273 of the 5x5 Gaussian blur.
// Depends on gb5_pkg (kernel, reciprocal, tap_ctl_t).
`timescale 1ns / 1ps

module gb5_conv
	import gb5_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             col_valid,
	input  logic [4:0][23:0] col_vec,
	input  tap_ctl_t         col_ctl,
	output logic             res_valid,
	output logic [23:0]      res_pix,
	output logic             res_last
);

	logic [23:0] win_q [0:4][0:4];

	logic        v_s2;
	tap_ctl_t    ctl_s2;
	logic        v_s3;
	logic        emit_s3;
	logic        last_s3;
	logic [14:0] rsum_s3 [0:2][0:4];
	logic        v_s4;
	logic        emit_s4;
	logic        last_s4;
	logic [16:0] tot_s4 [0:2];

	logic [14:0] rsum [0:2][0:4];
	logic [16:0] tot  [0:2];
	logic [34:0] prod [0:2];

	// Shift the window left by one column, new column enters on the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				for (int j = 0; j < 5; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (col_valid) begin
			for (int i = 0; i < 5; i++) begin
				for (int j = 0; j < 4; j++) begin
					win_q[i][j] <= win_q[i][j + 1];
				end
				win_q[i][4] <= col_vec[i];
			end
		end
	end

	// Row sums per channel, taps outside the frame dropped
	always_comb begin
		logic [7:0] p;
		for (int c = 0; c < 3; c++) begin
			for (int i = 0; i < 5; i++) begin
				rsum[c][i] = '0;
				for (int j = 0; j < 5; j++) begin
					p = (ctl_s2.row_ok[i] && ctl_s2.col_ok[j]) ? win_q[i][j][8*c +: 8] : 8'd0;
					rsum[c][i] = rsum[c][i] + 15'(KERN[i][j]) * 15'(p);
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			tot[c] = '0;
			for (int i = 0; i < 5; i++) begin
				tot[c] = tot[c] + 17'(rsum_s3[c][i]);
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod[c] = 35'(tot_s4[c]) * 35'(RECIP_273);
			res_pix[8*c +: 8] = prod[c][RECIP_SHIFT +: 8];
		end
	end

	assign res_valid = v_s4 && emit_s4;
	assign res_last  = last_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= col_valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2  <= col_ctl;
		emit_s3 <= ctl_s2.emit;
		last_s3 <= ctl_s2.last;
		rsum_s3 <= rsum;
		emit_s4 <= emit_s3;
		last_s4 <= last_s3;
		tot_s4  <= tot;
	end

endmodule

/* hdl/gaussian_blur_5x5_rgb.sv */
// Top level of the 5x5 Gaussian blur: APB registers, raster counters,
// line buffer memory and output queue. Depends on gb5_pkg and gb5_conv.
`timescale 1ns / 1ps

// Usage
// Slave stream takes RGB pixels in raster order: s_tdata = red, green, blue
// from bit 0 up, s_tuser = 1 marks a drain request (pixel value ignored).
// After a frame, 2*width+2 drain requests flush the remaining results.
// Master stream gives one blurred pixel per request once the request two rows
// and two columns further on has arrived; m_tlast marks the frame's last pixel.
// Writing image_width (0x0) or image_height (0x4) restarts the frame; write only
// while no request is in flight.
// Throughput: one request per cycle while s_tready is high; the line buffer
// memory is read and written once per request. A result passes the stage 1,
// s2, s3 and s4 registers and the output queue before it shows on m_tvalid.
// Results queue in an 8-entry buffer; when the receiver stalls, s_tready
// drops as soon as the buffer could not take everything in flight.
// Reset restores 1024 x 1024, clears the window and counters; the line buffer
// is not cleared, its stale rows never reach a result.
module gaussian_blur_5x5_rgb
	import gb5_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Pixel stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // red_in [7:0], green_in [15:8], blue_in [23:16]
	input  logic        s_tuser,  // action
	// Blurred stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // red_out [7:0], green_out [15:8], blue_out [23:16]
	output logic        m_tlast
);

	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int WW        = $clog2(MAX_WIDTH + 1);
	localparam int PW        = $clog2(2 * MAX_WIDTH + 2);
	localparam int PTRW      = $clog2(FIFO_DEPTH);
	localparam int CNTW      = $clog2(FIFO_DEPTH + 1);
	localparam int RDY_LIMIT = FIFO_DEPTH - PIPE_DEPTH - 1;

	function automatic logic [WW-1:0] clamp_width(input logic [10:0] v);
		if (v == 11'd0) begin
			return WW'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			return WW'(MAX_WIDTH);
		end
		return WW'(v);
	endfunction

	// Configuration
	logic [10:0]   image_width_q;
	logic [15:0]   image_height_q;
	logic [WW-1:0] ew_q;
	logic [15:0]   eh_q;

	// Raster position
	logic [CW-1:0] in_col_q;
	logic [CW-1:0] out_col_q;
	logic [15:0]   out_row_q;
	logic [PW-1:0] pos_q;
	logic          warm_q;

	// Line buffer memory: four rows above, newest in the low 24 bits
	logic [95:0]   line_mem [0:MAX_WIDTH-1];
	logic [95:0]   rd_q;
	logic [95:0]   fwd_data_q;
	logic          fwd_q;
	logic [95:0]   line_word;
	logic [95:0]   wr_word;

	logic          v_s1;
	logic [23:0]   pix_s1;
	logic [CW-1:0] col_s1;
	tap_ctl_t      ctl_s1;

	logic             cfg_wr;
	logic             acc;
	logic [WW-1:0]    w_last;
	logic [WW-1:0]    in_col_ext;
	logic [WW-1:0]    out_col_ext;
	logic [PW-1:0]    warm_at;
	logic             frame_last;
	tap_ctl_t         ctl_new;
	logic [4:0][23:0] col_vec;

	logic             res_valid;
	logic [23:0]      res_pix;
	logic             res_last;

	logic [24:0]     fifo_q [0:FIFO_DEPTH-1];
	logic [PTRW-1:0] wr_ptr_q;
	logic [PTRW-1:0] rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            pop;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			REG_IMAGE_WIDTH:  prdata = {21'd0, image_width_q};
			REG_IMAGE_HEIGHT: prdata = {16'd0, image_height_q};
			default:          prdata = '0;
		endcase
	end

	assign s_tready = cnt_q <= CNTW'(RDY_LIMIT);
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		in_col_ext  = WW'(in_col_q);
		out_col_ext = WW'(out_col_q);
		w_last      = ew_q - WW'(1);
		warm_at     = PW'({ew_q, 1'b0}) + PW'(1);
		frame_last  = warm_q && (out_row_q == eh_q - 16'd1) && (out_col_ext == w_last);

		ctl_new.emit      = warm_q;
		ctl_new.last      = frame_last;
		ctl_new.row_ok[0] = out_row_q >= 16'd2;
		ctl_new.row_ok[1] = out_row_q != 16'd0;
		ctl_new.row_ok[2] = 1'b1;
		ctl_new.row_ok[3] = (17'(out_row_q) + 17'd1) < 17'(eh_q);
		ctl_new.row_ok[4] = (17'(out_row_q) + 17'd2) < 17'(eh_q);
		ctl_new.col_ok[0] = out_col_ext >= WW'(2);
		ctl_new.col_ok[1] = out_col_ext != WW'(0);
		ctl_new.col_ok[2] = 1'b1;
		ctl_new.col_ok[3] = ((WW+1)'(out_col_q) + (WW+1)'(1)) < (WW+1)'(ew_q);
		ctl_new.col_ok[4] = ((WW+1)'(out_col_q) + (WW+1)'(2)) < (WW+1)'(ew_q);
	end

	// Registers and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMG_WIDTH_RESET;
			image_height_q <= IMG_HEIGHT_RESET;
			ew_q           <= clamp_width(IMG_WIDTH_RESET);
			eh_q           <= IMG_HEIGHT_RESET;
			in_col_q       <= '0;
			out_col_q      <= '0;
			out_row_q      <= '0;
			pos_q          <= '0;
			warm_q         <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_IMAGE_WIDTH: begin
					image_width_q <= pwdata[10:0];
					ew_q          <= clamp_width(pwdata[10:0]);
				end
				REG_IMAGE_HEIGHT: begin
					image_height_q <= pwdata[15:0];
					eh_q           <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
				end
				default: begin
				end
			endcase
			in_col_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pos_q     <= '0;
			warm_q    <= 1'b0;
		end else if (acc) begin
			if (frame_last) begin
				in_col_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				pos_q     <= '0;
				warm_q    <= 1'b0;
			end else begin
				in_col_q <= (in_col_ext == w_last) ? '0 : in_col_q + CW'(1);
				if (warm_q) begin
					if (out_col_ext == w_last) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 16'd1;
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end else begin
					pos_q <= pos_q + PW'(1);
					if (pos_q == warm_at) begin
						warm_q <= 1'b1;
					end
				end
			end
		end
	end

	// Stage 1: request captured, line buffer read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= s_tuser ? 24'd0 : s_tdata;
		col_s1 <= in_col_q;
		ctl_s1 <= ctl_new;
	end

	// Forward the word written this cycle when the next read hits the same column
	assign line_word = fwd_q ? fwd_data_q : rd_q;
	assign wr_word   = {line_word[71:0], pix_s1};

	always_comb begin
		col_vec[4] = pix_s1;
		col_vec[3] = line_word[23:0];
		col_vec[2] = line_word[47:24];
		col_vec[1] = line_word[71:48];
		col_vec[0] = line_word[95:72];
	end

	always_ff @(posedge clk) begin
		rd_q <= line_mem[in_col_q];
		if (v_s1) begin
			line_mem[col_s1] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else begin
			fwd_q <= v_s1 && (col_s1 == in_col_q);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= wr_word;
	end

	gb5_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.col_valid (v_s1),
		.col_vec   (col_vec),
		.col_ctl   (ctl_s1),
		.res_valid (res_valid),
		.res_pix   (res_pix),
		.res_last  (res_last)
	);

	// Output queue
	assign m_tvalid = cnt_q != '0;
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = fifo_q[rd_ptr_q][23:0];
	assign m_tlast  = fifo_q[rd_ptr_q][24];

	always_ff @(posedge clk) begin
		if (res_valid) begin
			fifo_q[wr_ptr_q] <= {res_last, res_pix};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= wr_ptr_q + PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTRW'(1);
			end
			if (res_valid && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !res_valid) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

endmodule

/* sim/gb5_blur_check.sv */
// Checker for the 5x5 Gaussian blur: follows the register port and both pixel
// streams, predicts every blurred pixel and compares it. Depends on gb5_pkg.
`timescale 1ns / 1ps

module gb5_blur_check
	import gb5_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // red_in [7:0], green_in [15:8], blue_in [23:16]
	input  logic        s_tuser,  // action
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,  // red_out [7:0], green_out [15:8], blue_out [23:16]
	input  logic        m_tlast,
	output int          fail_count,
	output int          outstanding
);

	localparam int unsigned LINE_W = MAX_WIDTH_DEF;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} blur_px_t;

	blur_px_t    blurred_px_q [$];

	logic [23:0] line_mem [0:4*LINE_W-1];
	logic [23:0] win [0:4][0:4];
	logic [10:0] width_reg;
	logic [15:0] height_reg;
	int unsigned in_col, in_row, out_col, out_row;

	function automatic int unsigned gauss_tap(input int i, input int j);
		int di;
		int dj;
		di = (i < 2) ? 2 - i : i - 2;
		dj = (j < 2) ? 2 - j : j - 2;
		case (di * 3 + dj)
			0: return 41;
			1, 3: return 26;
			2, 6: return 7;
			4: return 16;
			5, 7: return 4;
			default: return 1;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		// keep the log short on a badly broken block, but count everything
		if (fail_count < 40)
			$display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		fail_count = fail_count + 1;
	endtask

	task automatic restart_frame();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endtask

	// One accepted request: shift line buffers and window, maybe emit a pixel
	task automatic blur_window_step(input logic drain, input logic [23:0] px_in);
		int unsigned w, h, col, pos;
		logic [23:0] px;
		logic [23:0] colv [0:4];
		int          rr, cc;
		int unsigned sr, sg, sb, k;
		logic [23:0] p;
		blur_px_t    res;

		w = (width_reg == 0) ? 1 : ((width_reg > LINE_W) ? LINE_W : width_reg);
		h = (height_reg == 0) ? 1 : height_reg;
		col = (in_col < w) ? in_col : w - 1;
		px = drain ? 24'h0 : px_in;

		colv[4] = px;
		for (int i = 0; i < 4; i++)
			colv[3 - i] = line_mem[i * LINE_W + col];
		for (int i = 3; i > 0; i--)
			line_mem[i * LINE_W + col] = line_mem[(i - 1) * LINE_W + col];
		line_mem[col] = px;

		for (int i = 0; i < 5; i++) begin
			for (int j = 0; j < 4; j++)
				win[i][j] = win[i][j + 1];
			win[i][4] = colv[i];
		end

		pos = in_row * w + col;
		if (pos < 2 * w + 2) begin
			in_col = col + 1;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			return;
		end

		sr = 0;
		sg = 0;
		sb = 0;
		for (int i = 0; i < 5; i++) begin
			rr = int'(out_row) + i - 2;
			if (rr < 0 || rr >= int'(h))
				continue;
			for (int j = 0; j < 5; j++) begin
				cc = int'(out_col) + j - 2;
				if (cc < 0 || cc >= int'(w))
					continue;
				p = win[i][j];
				k = gauss_tap(i, j);
				sr += k * p[7:0];
				sg += k * p[15:8];
				sb += k * p[23:16];
			end
		end
		res.red = 8'(sr / 273);
		res.green = 8'(sg / 273);
		res.blue = 8'(sb / 273);
		res.last = (out_row == h - 1) && (out_col == w - 1);
		blurred_px_q.push_back(res);

		if (res.last) begin
			restart_frame();
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
			in_col = col + 1;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		blur_px_t want;

		if (!arst_n) begin
			width_reg = IMG_WIDTH_RESET;
			height_reg = IMG_HEIGHT_RESET;
			for (int i = 0; i < 4 * LINE_W; i++)
				line_mem[i] = 24'h0;
			for (int i = 0; i < 5; i++)
				for (int j = 0; j < 5; j++)
					win[i][j] = 24'h0;
			restart_frame();
			blurred_px_q.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (blurred_px_q.size() == 0) begin
					report_mismatch("blurred pixel with none expected", m_tdata, 0);
				end else begin
					want = blurred_px_q.pop_front();
					if (m_tdata[7:0] != want.red)
						report_mismatch("red_out", m_tdata[7:0], want.red);
					if (m_tdata[15:8] != want.green)
						report_mismatch("green_out", m_tdata[15:8], want.green);
					if (m_tdata[23:16] != want.blue)
						report_mismatch("blue_out", m_tdata[23:16], want.blue);
					if (m_tlast != want.last)
						report_mismatch("frame_last", m_tlast, want.last);
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_IMAGE_WIDTH)
					width_reg = pwdata[10:0];
				else
					height_reg = pwdata[15:0];
				restart_frame();
			end
			if (s_tvalid && s_tready)
				blur_window_step(s_tuser, s_tdata);
			outstanding <= blurred_px_q.size();
		end
	end

endmodule

/* sim/tb_top.sv */
// Top of the Gaussian blur testbench: clock, reset, register writes, pixel
// frames and receiver stalls. Depends on gb5_pkg, gb5_blur_check and the RTL.
`timescale 1ns / 1ps

module tb_top;
	import gb5_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 750;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = 24'd0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tlast;

	int          fail_count;
	int          outstanding;
	int          cycle_count = 0;
	int          sent_items = 0;
	int          rx_hold = 0;
	bit          s_calm = 1'b0;
	bit          m_calm = 1'b0;

	gaussian_blur_5x5_rgb i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	gb5_blur_check i_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [23:0] rand_px();
		return {rand_chan(), rand_chan(), rand_chan()};
	endfunction

	function automatic int unsigned frame_width(input int unsigned reg_val);
		if (reg_val == 0)
			return 1;
		return (reg_val > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : reg_val;
	endfunction

	// Offer one request after a random gap and hold it until accepted
	task automatic send_item(input logic drain, input logic [23:0] px);
		int unsigned gap;
		if ($urandom_range(0, 47) == 0)
			s_calm = !s_calm;
		gap = s_calm ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= drain;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		sent_items++;
	endtask

	// Pixels of a w x h frame, then the drain tail; noisy frames mix in
	// drains inside the frame, pixels in the tail and cut-short tails
	task automatic send_frame(input int unsigned w, input int unsigned h, input bit noisy);
		int unsigned tail;
		for (int unsigned k = 0; k < w * h; k++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				send_item(1'b1, rand_px());
			else
				send_item(1'b0, rand_px());
		end
		tail = 2 * w + 2;
		if (noisy && $urandom_range(0, 9) == 0)
			tail = $urandom_range(0, tail);
		for (int unsigned k = 0; k < tail; k++) begin
			if (noisy && $urandom_range(0, 7) == 0)
				send_item(1'b0, rand_px());
			else
				send_item(1'b1, rand_px());
		end
	endtask

	// Drop valid, wait for every blurred pixel, then let the pipeline empty
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic apb_write(input logic sel, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_frame(input logic [31:0] w_val, input logic [31:0] h_val);
		apb_write(REG_IMAGE_WIDTH, w_val);
		apb_write(REG_IMAGE_HEIGHT, h_val);
	endtask

	// Receiver: random stalls per pixel, plus a long hold-off on request
	initial begin
		int unsigned gap;
		forever begin
			if (rx_hold != 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			if ($urandom_range(0, 47) == 0)
				m_calm = !m_calm;
			gap = m_calm ? 0 : $urandom_range(0, 4);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		int          start_items;
		int unsigned w_val, h_val, frames;
		bit          held;

		held = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 frame with extreme values; the last pixel comes as a drain,
		// and two pixels arrive in the tail where they must be ignored
		set_frame(3, 3);
		send_item(1'b0, 24'h000000);
		send_item(1'b0, 24'hFFFFFF);
		send_item(1'b0, 24'hFF00FF);
		send_item(1'b0, 24'h00FF00);
		send_item(1'b0, 24'h55AA55);
		send_item(1'b0, 24'hAA55AA);
		send_item(1'b0, 24'h0180FE);
		send_item(1'b0, 24'hFFFFFF);
		send_item(1'b1, 24'hFFFFFF);
		for (int k = 0; k < 8; k++)
			send_item((k == 2 || k == 5) ? 1'b0 : 1'b1, 24'hFFFFFF);
		settle();

		// zero registers act as a single pixel frame
		set_frame(0, 0);
		send_frame(1, 1, 1'b0);
		settle();

		// widest setting clamps to the line length; cut off before any output
		set_frame(2047, 1);
		repeat (100) send_item(1'b0, rand_px());
		settle();

		// the receiver holds off while the frame streams out
		rx_hold = HOLD_CYCLES;
		set_frame(32, 8);
		send_frame(32, 8, 1'b0);
		settle();

		// partial frames, cut off by the next register write
		set_frame(MAX_WIDTH_DEF, 3);
		repeat (60) send_item(1'b0, rand_px());
		settle();
		set_frame(4, 65535);
		repeat (150) send_item($urandom_range(0, 15) == 0, rand_px());
		settle();

		start_items = sent_items;
		while (sent_items - start_items < RANDOM_ITEMS) begin
			w_val = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			h_val = $urandom_range(1, 6);
			if (w_val == 1 && $urandom_range(0, 1) == 0)
				w_val = 0;
			if (h_val == 1 && $urandom_range(0, 1) == 0)
				h_val = 0;
			set_frame(w_val, h_val);
			if (!held && sent_items - start_items > RANDOM_ITEMS / 2) begin
				rx_hold = HOLD_CYCLES;
				held = 1'b1;
			end
			frames = $urandom_range(1, 3);
			repeat (frames) send_frame(frame_width(w_val), (h_val == 0) ? 1 : h_val, 1'b1);
			settle();
		end

		if (fail_count == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
